// File: sv/lerr_pkg.sv
`default_nettype none

package lerr_pkg;

    // ring geometry
    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int BYTE_W = 8;
    localparam int FILL_W = 7;
    localparam int FILL_MAX = (1 << FILL_W) - 1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [IDX_W:0]    idx_ext_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [FILL_W-1:0] fill_t;

    // item operation codes
    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_PULL    = 2'd1,
        OP_FLUSH   = 2'd2
    } op_t;

    // line editing characters
    localparam byte_t CHAR_CR  = 8'h0D;
    localparam byte_t CHAR_BS  = 8'h08;
    localparam byte_t CHAR_DEL = 8'h7F;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // item accepted, start store access
        logic execute;   // update indices, load result register
    } cmd_t;

    function automatic idx_t idx_next(input idx_t i);
        idx_t r;
        if (i == idx_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        idx_t r;
        if (i == '0)
        begin
            r = idx_t'(DEPTH - 1);
        end
        else
        begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

    function automatic fill_t ring_fill(input idx_t wi, input idx_t ri);
        idx_ext_t d;
        fill_t    r;
        d = {1'b0, wi} - {1'b0, ri};
        if (d[IDX_W])
        begin
            d = d + idx_ext_t'(DEPTH);
        end
        if (d > idx_ext_t'(FILL_MAX))
        begin
            r = fill_t'(FILL_MAX);
        end
        else
        begin
            r = fill_t'(d);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/lerr_if.sv
`default_nettype none

// input channel: one item per handshake
interface lerr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// result channel
interface lerr_out_if;
    logic        valid;
    logic        ready;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        line_ready;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        line_end;
    logic [6:0]  fill_count;

    modport source (output valid, output echo_valid, output echo_byte, output line_ready,
                    output read_valid, output read_byte, output line_end,
                    output fill_count, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input line_ready,
                    input read_valid, input read_byte, input line_end,
                    input fill_count, output ready);
endinterface

`default_nettype wire

// File: sv/lerr_ram.sv
`default_nettype none

module lerr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/lerr_ctrl.sv
`default_nettype none

module lerr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lerr_pkg::cmd_t     cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec_go;

    assign in_ready = (state_reg == ST_IDLE);
    // result register is free when empty or being drained this cycle
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && (state_reg == ST_IDLE);
    assign cmd.execute = exec_go;

endmodule

`default_nettype wire

// File: sv/lerr_dp.sv
`default_nettype none

module lerr_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lerr_pkg::cmd_t        cmd,
    input  wire logic [1:0]            op,
    input  wire lerr_pkg::byte_t       rx_byte,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,
    output logic                       echo_valid,
    output lerr_pkg::byte_t            echo_byte,
    output logic                       line_ready,
    output logic                       read_valid,
    output lerr_pkg::byte_t            read_byte,
    output logic                       line_end,
    output lerr_pkg::fill_t            fill_count
);

    logic            echo_en_reg;
    logic [1:0]      op_reg;
    lerr_pkg::byte_t byte_reg;
    lerr_pkg::idx_t  rd_idx_reg, rd_idx_next;
    lerr_pkg::idx_t  wr_idx_reg, wr_idx_next;
    lerr_pkg::idx_t  ram_addr;
    lerr_pkg::byte_t ram_rdata;
    logic            ram_we;

    logic            echo_valid_reg, echo_valid_next;
    lerr_pkg::byte_t echo_byte_reg, echo_byte_next;
    logic            line_ready_reg, line_ready_next;
    logic            read_valid_reg, read_valid_next;
    lerr_pkg::byte_t read_byte_reg, read_byte_next;
    logic            line_end_reg, line_end_next;
    lerr_pkg::fill_t fill_reg;

    // single port store: receive writes at the write index, others read the oldest
    assign ram_we   = cmd.capture && (op == lerr_pkg::OP_RECEIVE);
    assign ram_addr = (op == lerr_pkg::OP_RECEIVE) ? wr_idx_reg : rd_idx_reg;

    lerr_ram #(
        .WIDTH (lerr_pkg::BYTE_W),
        .DEPTH (lerr_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (cmd.capture),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (rx_byte),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        lerr_pkg::idx_t w1;
        lerr_pkg::idx_t w2;
        w1 = '0;
        w2 = '0;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        echo_valid_next = 1'b0;
        echo_byte_next  = '0;
        line_ready_next = 1'b0;
        read_valid_next = 1'b0;
        read_byte_next  = '0;
        line_end_next   = 1'b0;
        case (op_reg)
            lerr_pkg::OP_RECEIVE:
            begin
                // advance unless full, then up to two pops for erase keys
                w1 = lerr_pkg::idx_next(wr_idx_reg);
                if (w1 == rd_idx_reg)
                begin
                    w1 = wr_idx_reg;
                end
                if ((byte_reg == lerr_pkg::CHAR_BS) || (byte_reg == lerr_pkg::CHAR_DEL))
                begin
                    if (w1 != rd_idx_reg)
                    begin
                        w1 = lerr_pkg::idx_prev(w1);
                    end
                    w2 = w1;
                    if (w2 != rd_idx_reg)
                    begin
                        w2 = lerr_pkg::idx_prev(w2);
                    end
                    w1 = w2;
                end
                wr_idx_next = w1;
                if (echo_en_reg)
                begin
                    echo_valid_next = 1'b1;
                    echo_byte_next  = byte_reg;
                end
                line_ready_next = (byte_reg == lerr_pkg::CHAR_CR);
            end
            lerr_pkg::OP_PULL:
            begin
                if (rd_idx_reg != wr_idx_reg)
                begin
                    rd_idx_next     = lerr_pkg::idx_next(rd_idx_reg);
                    read_valid_next = 1'b1;
                    if (ram_rdata == lerr_pkg::CHAR_CR)
                    begin
                        line_end_next = 1'b1;
                    end
                    else
                    begin
                        read_byte_next = ram_rdata;
                    end
                end
            end
            lerr_pkg::OP_FLUSH:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
            end
            default:
            begin
                rd_idx_next = rd_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg <= 1'b1;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                echo_en_reg <= cfg_wdata;
            end
            if (cmd.execute)
            begin
                rd_idx_reg <= rd_idx_next;
                wr_idx_reg <= wr_idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
        if (cmd.execute)
        begin
            echo_valid_reg <= echo_valid_next;
            echo_byte_reg  <= echo_byte_next;
            line_ready_reg <= line_ready_next;
            read_valid_reg <= read_valid_next;
            read_byte_reg  <= read_byte_next;
            line_end_reg   <= line_end_next;
            fill_reg       <= lerr_pkg::ring_fill(wr_idx_next, rd_idx_next);
        end
    end

    assign echo_valid = echo_valid_reg;
    assign echo_byte  = echo_byte_reg;
    assign line_ready = line_ready_reg;
    assign read_valid = read_valid_reg;
    assign read_byte  = read_byte_reg;
    assign line_end   = line_end_reg;
    assign fill_count = fill_reg;

endmodule

`default_nettype wire

// File: sv/line_edit_receive_ring.sv
`default_nettype none

// Terminal receive ring with line editing. Each item on item_in is a receive
// (store the byte, echo it when echo is on, erase up to two newest bytes on
// backspace or DEL, flag a carriage return), a pull (return the oldest byte,
// a carriage return coming out as 0 with line_end set) or a flush (empty the
// ring). Every item gives exactly one result on result_out, carrying the fill
// count after the item. The ring holds at most DEPTH-1 bytes; a byte received
// while full is lost but still echoed and still edited. Each item is taken
// and the single-port byte store accessed, then the indices are updated and
// the result register loaded; a new item is taken only after that. A result
// waiting there does not hold off the next item, only its update and load.
// No clearing pass after reset. echo is on after reset; the user changes it
// through cfg_we/cfg_wdata while no item is in flight, unchecked by the block.

module line_edit_receive_ring (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lerr_in_if.sink       item_in,
    lerr_out_if.source    result_out,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);

    lerr_pkg::cmd_t cmd;

    // sequencing and handshake
    lerr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    // byte store, ring indices, echo register and result register
    lerr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (item_in.op),
        .rx_byte    (item_in.rx_byte),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .echo_valid (result_out.echo_valid),
        .echo_byte  (result_out.echo_byte),
        .line_ready (result_out.line_ready),
        .read_valid (result_out.read_valid),
        .read_byte  (result_out.read_byte),
        .line_end   (result_out.line_end),
        .fill_count (result_out.fill_count)
    );

endmodule

`default_nettype wire
